// ===== src/rzba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rotozoom box average package
// Shared widths, register indexes and operation codes.
// ----------------------------------------------------------------------------
package rzba_pkg;
    localparam int unsigned DefMaxDim  = 1024;
    localparam int unsigned DefMaxSpan = 16;

    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_SRC_W  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_SRC_H  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_OUT_W  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_OUT_H  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SIN    = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_COS    = 3'd5;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam int unsigned DimW  = 11;
    localparam int unsigned StepW = 26;
    localparam int unsigned CfgW  = 26;

    // Divider control between the top level and the divide unit.
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [12:0] divisor;
    } t_div_req;
endpackage
`default_nettype wire

// ===== src/rzba_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rotozoom box average divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rzba_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  rzba_pkg::t_div_req     i_req,
    output logic                   o_done,
    output logic [7:0]             o_quot
);
    import rzba_pkg::*;

    logic [15:0] r_num, n_num;
    logic [13:0] r_rem, n_rem;
    logic [12:0] r_den;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [13:0] w_trial;
    logic [14:0] w_diff;

    // One shift and compare per cycle.
    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem[12:0], r_num[15]};
        w_diff  = {1'b0, w_trial} - {2'b0, r_den};
        if (r_busy) begin
            n_num = {r_num[14:0], ~w_diff[14]};
            n_rem = w_diff[14] ? w_trial : w_diff[13:0];
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd16;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_busy && (r_cnt == 5'd1);
    assign o_quot = n_num[7:0];
endmodule
`default_nettype wire

// ===== src/rotozoom_box_average_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rotozoom box average unit
// Rotated, scaled resampling of a stored RGB565 image with box averaging.
// ----------------------------------------------------------------------------
// A load word (op 0) writes one source pixel in row-major order. A request word
// (op 1) returns one output pixel. An outside pixel goes through the position
// and done states; a copied one also reads the store once. A box of N pixels
// reads each pixel in turn, waiting on the registered store port before each
// sum, then runs three divides (one per channel) on the single shared divider;
// the single store read port and the divider set the rate. The first request
// of a frame also passes through the start multiply states. One word is worked
// on at a time; the finished result waits in an output register, and a
// stalled result holds the block in its done state.
// ----------------------------------------------------------------------------
module rotozoom_box_average_unit #(
    parameter int unsigned MAX_DIM  = rzba_pkg::DefMaxDim
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_op,
    input  wire logic [15:0]                   i_pixel_in,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [15:0]                        o_pixel_out,
    output logic                               o_outside,
    output logic                               o_frame_last,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [rzba_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [rzba_pkg::CfgW-1:0]     i_cfg_data
);
    import rzba_pkg::*;

    localparam int unsigned MaxSpan = DefMaxSpan;
    localparam int unsigned AddrW  = $clog2(MAX_DIM * MAX_DIM);
    localparam int unsigned Depth  = MAX_DIM * MAX_DIM;
    localparam int unsigned SpanW  = $clog2(MaxSpan);
    localparam logic [SpanW-1:0] SpanMax = SpanW'(MaxSpan - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_POS   = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_DIVR  = 4'd5;
    localparam logic [3:0] S_DIVG  = 4'd6;
    localparam logic [3:0] S_DIVB  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_START = 4'd9;

    // Configuration registers.
    logic [DimW-1:0]  r_src_w, r_src_h, r_out_w, r_out_h;
    logic [StepW-1:0] r_sin, r_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= DimW'(320);
            r_src_h <= DimW'(240);
            r_out_w <= DimW'(320);
            r_out_h <= DimW'(240);
            r_sin   <= '0;
            r_cos   <= StepW'(65536);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_W: r_src_w <= i_cfg_data[DimW-1:0];
                CFG_SRC_H: r_src_h <= i_cfg_data[DimW-1:0];
                CFG_OUT_W: r_out_w <= i_cfg_data[DimW-1:0];
                CFG_OUT_H: r_out_h <= i_cfg_data[DimW-1:0];
                CFG_SIN:   r_sin   <= i_cfg_data;
                CFG_COS:   r_cos   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // Saturated sizes.
    logic [12:0] w_sw, w_sh, w_ow, w_oh;
    always_comb begin
        w_sw = (13'(r_src_w) > 13'(MAX_DIM)) ? 13'(MAX_DIM) : 13'(r_src_w);
        w_sh = (13'(r_src_h) > 13'(MAX_DIM)) ? 13'(MAX_DIM) : 13'(r_src_h);
        w_ow = (13'(r_out_w) > 13'(MAX_DIM)) ? 13'(MAX_DIM) :
               (r_out_w == '0) ? 13'd1 : 13'(r_out_w);
        w_oh = (13'(r_out_h) > 13'(MAX_DIM)) ? 13'(MAX_DIM) :
               (r_out_h == '0) ? 13'd1 : 13'(r_out_h);
    end
    logic [31:0] w_sin32, w_cos32;
    assign w_sin32 = 32'(signed'(r_sin));
    assign w_cos32 = 32'(signed'(r_cos));

    // Sequencer state.
    logic [3:0]       r_state;
    logic [AddrW-1:0] r_load_ptr;
    logic [12:0]      r_col, r_row;
    logic [31:0]      r_rsx, r_rsy, r_wx, r_wy, r_mx, r_my;
    logic signed [16:0] r_pcol, r_prow;
    logic signed [16:0] r_cx, r_cy;
    logic [SpanW-1:0] r_sx, r_i, r_j;
    logic             r_box;
    logic [15:0]      r_rs, r_gs, r_bs;
    logic [12:0]      r_n;
    logic [15:0]      r_pix;
    logic [4:0]       r_qr;
    logic [5:0]       r_qg;
    logic             r_ovalid, r_outside, r_last;

    // Pixel store: one write and one registered read port.
    logic [15:0] r_mem [Depth];
    logic [15:0] r_rdata;
    logic [AddrW-1:0] w_raddr;
    logic        w_we;
    assign w_we = i_valid && !o_stall && (i_op == OP_LOAD);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_load_ptr] <= i_pixel_in;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // Read address: (cy - j) * sw + (cx - i), taken modulo depth.
    logic [31:0] w_ra;
    always_comb begin
        w_ra = 32'(r_cy - 17'(r_j)) * 32'(w_sw) + 32'(r_cx - 17'(r_i));
        w_raddr = w_ra[AddrW-1:0];
    end

    // Shared divider.
    t_div_req    w_dreq;
    logic        w_ddone;
    logic [7:0]  w_dq;
    rzba_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_done  (w_ddone),
        .o_quot  (w_dq)
    );

    // Current position and spans.
    logic signed [16:0] w_cx, w_cy, w_dx, w_dy;
    logic w_out;
    logic [SpanW-1:0] w_spx, w_spy;
    always_comb begin
        w_cx = 17'(signed'(r_wx[31:16]));
        w_cy = 17'(signed'(r_wy[31:16]));
        w_out = w_cx[16] || w_cy[16] || (w_cx >= 17'(w_sw)) || (w_cy >= 17'(w_sh));
        w_dx = w_cx - r_pcol;
        w_dy = w_cy - r_prow;
        w_spx = w_dx[16] ? '0 : (w_dx > 17'(SpanMax)) ? SpanMax : w_dx[SpanW-1:0];
        w_spy = w_dy[16] ? '0 : (w_dy > 17'(SpanMax)) ? SpanMax : w_dy[SpanW-1:0];
        if (17'(w_spx) > w_cx) w_spx = w_cx[SpanW-1:0];
        if (17'(w_spy) > w_cy) w_spy = w_cy[SpanW-1:0];
    end

    // Channel expansion of the read word.
    logic [7:0] w_r8, w_g8, w_b8;
    assign w_r8 = {r_rdata[15:11], r_rdata[15:13]};
    assign w_g8 = {r_rdata[10:5], r_rdata[10:9]};
    assign w_b8 = {r_rdata[4:0], r_rdata[4:2]};

    logic w_in_acc;
    assign w_in_acc = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE) || (r_ovalid && i_stall);

    // The red divide starts on the last box read, so its sum takes that word too.
    always_comb begin
        w_dreq.start    = 1'b0;
        w_dreq.dividend = r_rs;
        w_dreq.divisor  = r_n;
        case (r_state)
            S_ACC: begin
                w_dreq.start    = (r_i == '0) && (r_j == '0) && r_box;
                w_dreq.dividend = r_rs + 16'(w_r8);
            end
            S_DIVR: begin
                w_dreq.start    = w_ddone;
                w_dreq.dividend = r_gs;
            end
            S_DIVG: begin
                w_dreq.start    = w_ddone;
                w_dreq.dividend = r_bs;
            end
            default: begin
            end
        endcase
    end

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_load_ptr <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_wx       <= '0;
            r_wy       <= '0;
            r_pcol     <= '0;
            r_prow     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_op == OP_LOAD) begin
                            r_load_ptr <= (r_load_ptr == AddrW'(Depth - 1)) ? '0
                                          : r_load_ptr + AddrW'(1);
                        end else if (r_col == '0 && r_row == '0) begin
                            r_state <= S_START;
                        end else begin
                            r_state <= S_POS;
                        end
                    end
                end
                S_START: begin
                    r_mx <= 32'(w_ow >> 1) * (w_cos32 + w_sin32);
                    r_my <= 32'(w_oh >> 1) * (w_cos32 - w_sin32);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_rsx  <= (32'(w_sw) << 15) - r_mx;
                    r_rsy  <= (32'(w_sh) << 15) - r_my;
                    r_wx   <= (32'(w_sw) << 15) - r_mx;
                    r_wy   <= (32'(w_sh) << 15) - r_my;
                    r_pcol <= '0;
                    r_prow <= '0;
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_cx <= w_cx;
                    r_cy <= w_cy;
                    r_outside <= w_out;
                    r_box <= (w_dx > 0) || (w_dy > 0);
                    r_sx <= ((w_dx > 0) || (w_dy > 0)) ? w_spx : '0;
                    r_i  <= ((w_dx > 0) || (w_dy > 0)) ? w_spx : '0;
                    r_j  <= ((w_dx > 0) || (w_dy > 0)) ? w_spy : '0;
                    r_n  <= 13'((14'(w_spx) + 14'd1) * (14'(w_spy) + 14'd1));
                    r_rs <= '0;
                    r_gs <= '0;
                    r_bs <= '0;
                    r_state <= w_out ? S_DONE : S_READ;
                end
                S_READ: begin
                    // Address for (r_i, r_j) is presented; data arrives next.
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_rs <= r_rs + 16'(w_r8);
                    r_gs <= r_gs + 16'(w_g8);
                    r_bs <= r_bs + 16'(w_b8);
                    if (!r_box) begin
                        r_pix   <= r_rdata;
                        r_state <= S_DONE;
                    end else if (r_i != '0) begin
                        r_i <= r_i - SpanW'(1);
                        r_state <= S_READ;
                    end else if (r_j != '0) begin
                        r_i <= r_sx;
                        r_j <= r_j - SpanW'(1);
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_DIVR;
                    end
                end
                S_DIVR: begin
                    if (w_ddone) begin
                        r_qr <= w_dq[7:3];
                        r_state <= S_DIVG;
                    end
                end
                S_DIVG: begin
                    if (w_ddone) begin
                        r_qg <= w_dq[7:2];
                        r_state <= S_DIVB;
                    end
                end
                S_DIVB: begin
                    if (w_ddone) begin
                        r_pix <= {r_qr, r_qg, w_dq[7:3]};
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid     <= 1'b1;
                        o_pixel_out  <= r_outside ? 16'd0 : r_pix;
                        o_outside    <= r_outside;
                        r_prow       <= r_cy;
                        r_state      <= S_IDLE;
                        if (r_col + 13'd1 >= w_ow) begin
                            r_col  <= '0;
                            r_pcol <= '0;
                            r_rsx  <= r_rsx + w_sin32;
                            r_rsy  <= r_rsy + w_cos32;
                            r_wx   <= r_rsx + w_sin32;
                            r_wy   <= r_rsy + w_cos32;
                            if (r_row + 13'd1 >= w_oh) begin
                                r_row        <= '0;
                                o_frame_last <= 1'b1;
                            end else begin
                                r_row        <= r_row + 13'd1;
                                o_frame_last <= 1'b0;
                            end
                        end else begin
                            r_col        <= r_col + 13'd1;
                            r_pcol       <= r_cx;
                            r_wx         <= r_wx + w_cos32;
                            r_wy         <= r_wy - w_sin32;
                            o_frame_last <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;
endmodule
`default_nettype wire

// ===== tb/sv/tb_rotozoom_box_average_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotozoom box average unit testbench
// The testbench loads source images and sweeps the step and size registers.
// It predicts every output pixel with its own model of the coordinate walk
// and the box filter, and compares each result word field by field.
// ----------------------------------------------------------------------------
module tb_rotozoom_box_average_unit;
    import rzba_pkg::*;

    typedef struct {
        logic [15:0] pix;
        logic        outside;
        logic        last;
    } pixel_result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                in_op;
    logic [15:0]         in_pixel;
    logic                out_valid;
    logic                out_stall;
    logic [15:0]         out_pixel;
    logic                out_outside;
    logic                out_last;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgW-1:0]     cfg_data;

    rotozoom_box_average_unit dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_op         (in_op),
        .i_pixel_in   (in_pixel),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_pixel_out  (out_pixel),
        .o_outside    (out_outside),
        .o_frame_last (out_last),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    // Model of the source store and the walk state.
    logic [15:0]       src_mem [0:(1<<20)-1];
    logic [19:0]       load_ptr;
    int unsigned       loaded_count;
    int unsigned       col_cnt, row_cnt;
    logic [31:0]       row_x, row_y, walk_x, walk_y;
    int                last_col, last_row;
    logic [10:0]       reg_sw, reg_sh, reg_ow, reg_oh;
    logic [25:0]       reg_sin, reg_cos;

    pixel_result_t     expected_pixels[$];
    int unsigned       fail_count;
    int unsigned       rx_hold;
    bit                tx_burst;
    bit                rx_burst;

    // Clock.
    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog.
    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int clamp_span(int d, int cur);
        if (d < 0) d = 0;
        if (d > DefMaxSpan - 1) d = DefMaxSpan - 1;
        if (d > cur) d = cur;
        return d;
    endfunction

    function automatic logic [15:0] read_src(int c, int r, int unsigned sw);
        logic [31:0] addr;
        addr = r * sw + c;
        return src_mem[addr[19:0]];
    endfunction

    // Average the box of source pixels passed over, per channel.
    function automatic logic [15:0] box_filter(int cx, int cy, int sx, int sy,
                                               int unsigned sw);
        int unsigned rs, gs, bs, n;
        logic [15:0] p;
        logic [4:0]  r5, b5;
        logic [5:0]  g6;
        rs = 0;
        gs = 0;
        bs = 0;
        for (int j = 0; j <= sy; j++) begin
            for (int i = 0; i <= sx; i++) begin
                p  = read_src(cx - i, cy - j, sw);
                r5 = p[15:11];
                g6 = p[10:5];
                b5 = p[4:0];
                rs += {r5, r5[4:2]};
                gs += {g6, g6[5:4]};
                bs += {b5, b5[4:2]};
            end
        end
        n  = (sx + 1) * (sy + 1);
        rs = rs / n;
        gs = gs / n;
        bs = bs / n;
        return {rs[7:3], gs[7:2], bs[7:3]};
    endfunction

    // Work out the result word of one accepted request.
    task automatic predict_request(output pixel_result_t res);
        int unsigned sw, sh, ow, oh;
        logic [31:0] sin32, cos32;
        int          cx, cy, dx, dy;
        sw    = (reg_sw > 1024) ? 1024 : reg_sw;
        sh    = (reg_sh > 1024) ? 1024 : reg_sh;
        ow    = (reg_ow > 1024) ? 1024 : ((reg_ow == 0) ? 1 : reg_ow);
        oh    = (reg_oh > 1024) ? 1024 : ((reg_oh == 0) ? 1 : reg_oh);
        sin32 = {{6{reg_sin[25]}}, reg_sin};
        cos32 = {{6{reg_cos[25]}}, reg_cos};
        if (col_cnt == 0 && row_cnt == 0) begin
            row_x    = (32'(sw) << 15) - (32'(ow) >> 1) * (cos32 + sin32);
            row_y    = (32'(sh) << 15) - (32'(oh) >> 1) * (cos32 - sin32);
            walk_x   = row_x;
            walk_y   = row_y;
            last_col = 0;
            last_row = 0;
        end
        cx = $signed(walk_x[31:16]);
        cy = $signed(walk_y[31:16]);
        res.pix     = '0;
        res.last    = 1'b0;
        res.outside = (cx < 0 || cy < 0 || cx >= int'(sw) || cy >= int'(sh));
        if (!res.outside) begin
            dx = cx - last_col;
            dy = cy - last_row;
            if (dx > 0 || dy > 0)
                res.pix = box_filter(cx, cy, clamp_span(dx, cx), clamp_span(dy, cy), sw);
            else
                res.pix = read_src(cx, cy, sw);
        end
        walk_x   = walk_x + cos32;
        walk_y   = walk_y - sin32;
        last_col = cx;
        last_row = cy;
        col_cnt++;
        if (col_cnt >= ow) begin
            col_cnt  = 0;
            last_col = 0;
            row_x    = row_x + sin32;
            row_y    = row_y + cos32;
            walk_x   = row_x;
            walk_y   = row_y;
            row_cnt++;
            if (row_cnt >= oh) begin
                row_cnt  = 0;
                res.last = 1'b1;
            end
        end
    endtask

    // Offer one word and record what it should cause once accepted.
    task automatic send_word(logic op, logic [15:0] pix);
        int unsigned   gap;
        pixel_result_t res;
        @(negedge clk);
        in_valid = 1'b1;
        in_op    = op;
        in_pixel = pix;
        do @(posedge clk); while (in_stall);
        if (op == OP_LOAD) begin
            src_mem[load_ptr] = pix;
            load_ptr++;
            loaded_count++;
        end else begin
            predict_request(res);
            expected_pixels.push_back(res);
        end
        gap = tx_burst ? 0 : gap_len();
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            in_op    = 1'($urandom_range(0, 1));
            in_pixel = 16'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid and let the block finish all work before a register write.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        wait (expected_pixels.size() == 0);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SRC_W: reg_sw  = value[10:0];
            CFG_SRC_H: reg_sh  = value[10:0];
            CFG_OUT_W: reg_ow  = value[10:0];
            CFG_OUT_H: reg_oh  = value[10:0];
            CFG_SIN:   reg_sin = value;
            CFG_COS:   reg_cos = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned ow,
                                int unsigned oh, int sin_v, int cos_v);
        drain();
        write_reg(CFG_SRC_W, CfgW'(sw));
        write_reg(CFG_SRC_H, CfgW'(sh));
        write_reg(CFG_OUT_W, CfgW'(ow));
        write_reg(CFG_OUT_H, CfgW'(oh));
        write_reg(CFG_SIN, sin_v[25:0]);
        write_reg(CFG_COS, cos_v[25:0]);
    endtask

    task automatic send_requests(int unsigned count);
        repeat (count) send_word(OP_REQUEST, 16'($urandom));
    endtask

    // Load a 16 by 16 image, colour extremes first, then copy it one to one.
    task automatic test_identity_copy();
        logic [15:0] corner [5] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F};
        set_geometry(16, 16, 4, 4, 0, 65536);
        foreach (corner[k]) send_word(OP_LOAD, corner[k]);
        repeat (251) send_word(OP_LOAD, 16'($urandom));
        send_requests(16);
    endtask

    // Downscale and rotation take the box average path.
    task automatic test_box_paths();
        set_geometry(16, 16, 5, 5, 0, 3 * 65536);
        send_requests(25);
        set_geometry(16, 16, 6, 6, 46341, 46341);
        send_requests(36);
        set_geometry(16, 16, 3, 3, -20 * 65536, 20 * 65536);
        send_requests(9);
    endtask

    // Register extremes: huge sizes against an empty source (all outside), then saturated sizes.
    task automatic test_extremes();
        set_geometry(1024, 0, 2047, 0, -16777216, 16777216);
        send_requests(40);
        set_geometry(0, 1024, 1, 1024, 16777216, -16777216);
        send_requests(30);
        set_geometry(2047, 2047, 0, 2047, 0, 65536);
        send_requests(3);
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        set_geometry(16, 16, 8, 8, 12000, 70000);
        tx_burst = 1'b1;
        rx_hold  = 300;
        send_requests(30);
        tx_burst = 1'b0;
    endtask

    function automatic int rand_step();
        int mag;
        mag = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16777216)
                                          : $urandom_range(0, 5 * 65536);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Random geometry per phase, requests mixed with further loads.
    task automatic test_random_frames();
        int unsigned sent, sw, sh, n;
        sent = 0;
        while (sent < 1050) begin
            sw = $urandom_range(1, 40);
            sh = $urandom_range(1, (loaded_count / sw > 40) ? 40 : loaded_count / sw);
            if ($urandom_range(0, 15) == 0) sw = 0;
            set_geometry(sw, sh, $urandom_range(1, 12), $urandom_range(1, 12),
                         rand_step(), rand_step());
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 80);
            repeat (n) begin
                if ($urandom_range(0, 99) < 15)
                    send_word(OP_LOAD, 16'($urandom));
                else
                    send_word(OP_REQUEST, 16'($urandom));
            end
            sent += n;
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // Receiver stall pattern.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold > 0) begin
                out_stall = 1'b1;
                rx_hold--;
            end else if (rx_burst) begin
                out_stall = 1'b0;
            end else begin
                out_stall = (gap_len() > 0);
            end
        end
    end

    // Compare each accepted result word with the oldest expected one.
    always @(posedge clk) begin
        pixel_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result word pixel=%h", $time, out_pixel);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (out_pixel !== want.pix) begin
                    $display("%0t: pixel_out expected %h actual %h",
                             $time, want.pix, out_pixel);
                    fail_count++;
                end
                if (out_outside !== want.outside) begin
                    $display("%0t: outside expected %b actual %b",
                             $time, want.outside, out_outside);
                    fail_count++;
                end
                if (out_last !== want.last) begin
                    $display("%0t: frame_last expected %b actual %b",
                             $time, want.last, out_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_op        = OP_LOAD;
        in_pixel     = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_SRC_W;
        cfg_data     = '0;
        fail_count   = 0;
        rx_hold      = 0;
        tx_burst     = 1'b0;
        rx_burst     = 1'b0;
        load_ptr     = '0;
        loaded_count = 0;
        col_cnt      = 0;
        row_cnt      = 0;
        row_x        = '0;
        row_y        = '0;
        walk_x       = '0;
        walk_y       = '0;
        last_col     = 0;
        last_row     = 0;
        reg_sw       = 11'd320;
        reg_sh       = 11'd240;
        reg_ow       = 11'd320;
        reg_oh       = 11'd240;
        reg_sin      = '0;
        reg_cos      = 26'd65536;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_identity_copy();
        test_box_paths();
        test_extremes();
        test_backpressure();
        test_random_frames();

        @(negedge clk);
        in_valid = 1'b0;
        wait (expected_pixels.size() == 0);
        repeat (500) @(posedge clk);
        if (fail_count == 0 && expected_pixels.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
